// ----- rtl/core/vvi_pkg.sv -----
// ----------------------------------------------------------------------------
// vvi_pkg
// Shared codes, reset values and controller/datapath interface types for the
// VVI pacemaker core with beat monitor.
// ----------------------------------------------------------------------------
package vvi_pkg;

  localparam logic [1:0] MODE_VRP   = 2'd0;
  localparam logic [1:0] MODE_RI    = 2'd1;
  localparam logic [1:0] MODE_READY = 2'd2;

  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;

  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_REFRACTORY = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_UPPER_RATE = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_LOWER_RATE = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_WINDOW     = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_THRESHOLD  = 3'd4;

  localparam logic [15:0] RST_REFRACTORY = 16'd150;
  localparam logic [15:0] RST_UPPER_RATE = 16'd333;
  localparam logic [15:0] RST_LOWER_RATE = 16'd1500;
  localparam logic [7:0]  RST_WINDOW     = 8'd20;
  localparam logic [6:0]  RST_THRESHOLD  = 7'd70;

  typedef struct packed {
    logic tick;
    logic rep_start;
    logic scan;
    logic calc;
    logic div_start;
    logic div_sel;
    logic latch_q1;
    logic latch_q2;
    logic publish;
  } vvi_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic div_busy;
  } vvi_status_t;

endpackage

// ----- rtl/core/vvi_pacemaker_with_beat_monitor_core.sv -----
// ----------------------------------------------------------------------------
// vvi_pacemaker_with_beat_monitor_core
// VVI timing cycle on millisecond ticks with a beat ring and window report.
// ----------------------------------------------------------------------------
// Tick word: accept moves to S_DONE, which publishes the result word into the
// output register once it is free. Report word: a window scan with one ring
// read per cycle over the stored beats, then the bit-serial divider run twice.
// One word in flight; the output register lets the next word in while held.
// Reset: config to defaults, mode rate interval wait, clock, elapsed time, ring
// write slot and stored count cleared; ring contents are not cleared.
// ----------------------------------------------------------------------------
module vvi_pacemaker_with_beat_monitor_core import vvi_pkg::*; #(
  parameter int BEAT_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              command,
  input  logic              sense,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              pace,
  output logic [1:0]        mode,
  output logic [8:0]        beat_count,
  output logic [8:0]        paced_count,
  output logic [9:0]        paced_tenths,
  output logic [20:0]       rate_hundredths,
  output logic              slow_alarm,
  output logic              fast_alarm,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [15:0]       cfg_data
);

  vvi_cmd_t    cmd;
  vvi_status_t status;

  assign cfg_ready = 1'b1;

  vvi_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_command (command),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .status     (status)
  );

  vvi_datapath #(.BEAT_DEPTH(BEAT_DEPTH)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .sense           (sense),
    .cmd             (cmd),
    .status          (status),
    .pace            (pace),
    .mode            (mode),
    .beat_count      (beat_count),
    .paced_count     (paced_count),
    .paced_tenths    (paced_tenths),
    .rate_hundredths (rate_hundredths),
    .slow_alarm      (slow_alarm),
    .fast_alarm      (fast_alarm)
  );

  a_pace_starts_cycle: assert property (@(posedge clk) disable iff (rst)
    out_valid && pace |-> mode == MODE_VRP)
    else $error("pace word without refractory mode");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while first in progress");

  a_tick_no_stats: assert property (@(posedge clk) disable iff (rst)
    out_valid && pace |-> beat_count == 9'd0 && rate_hundredths == 21'd0 && !slow_alarm)
    else $error("tick word carries report fields");

  a_report_not_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command |=> !cmd.publish)
    else $error("report published before scan");

endmodule

// ----- rtl/core/vvi_div.sv -----
// ----------------------------------------------------------------------------
// vvi_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vvi_div #(
  parameter int NW = 22,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] numer,
  input  logic [DW-1:0] denom,
  output logic          busy,
  output logic [NW-1:0] quot
);

  localparam int KW = $clog2(NW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [NW-1:0] quo;
  logic [KW-1:0] count;

  logic [DW:0]   shifted;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] rem_next;

  always_comb begin
    shifted  = {rem, quo[NW-1]};
    diff     = shifted - {1'b0, den};
    ge       = (shifted >= {1'b0, den});
    rem_next = ge ? diff[DW-1:0] : shifted[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= KW'(NW);
    end else if (busy) begin
      count <= count - KW'(1);
      if (count == KW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      den <= denom;
      quo <= numer;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[NW-2:0], ge};
    end
  end

  assign quot = quo;

endmodule

// ----- rtl/core/vvi_datapath.sv -----
// ----------------------------------------------------------------------------
// vvi_datapath
// Config registers, VVI timing cycle, beat ring memory, window scan,
// alarm compare and shared divider for the report.
// ----------------------------------------------------------------------------
module vvi_datapath import vvi_pkg::*; #(
  parameter int BEAT_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              sense,
  input  vvi_cmd_t          cmd,
  output vvi_status_t       status,
  output logic              pace,
  output logic [1:0]        mode,
  output logic [8:0]        beat_count,
  output logic [8:0]        paced_count,
  output logic [9:0]        paced_tenths,
  output logic [20:0]       rate_hundredths,
  output logic              slow_alarm,
  output logic              fast_alarm
);

  localparam int AW  = (BEAT_DEPTH > 1) ? $clog2(BEAT_DEPTH) : 1;
  localparam int CW  = $clog2(BEAT_DEPTH + 1);
  localparam int DVW = (CW > 8) ? CW : 8;
  localparam int NW  = CW + 13;
  localparam int PW  = CW + 18;
  localparam logic [AW-1:0] LAST_SLOT = AW'(BEAT_DEPTH - 1);
  localparam logic [CW:0]   DEPTH_X   = (CW + 1)'(BEAT_DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(BEAT_DEPTH);

  logic [15:0] refractory_ms;
  logic [15:0] upper_rate_ms;
  logic [15:0] lower_rate_ms;
  logic [7:0]  window_s;
  logic [6:0]  pace_threshold_pct;

  logic [1:0]    mode_reg;
  logic [16:0]   elapsed_ms;
  logic [31:0]   now_ms;
  logic [AW-1:0] write_slot;
  logic [CW-1:0] stored_count;

  logic [32:0]   beat_ring [BEAT_DEPTH];
  logic [AW-1:0] ptr;
  logic [CW-1:0] remain;
  logic [32:0]   rd_data;
  logic          rd_valid;
  logic [CW-1:0] total;
  logic [CW-1:0] paced;

  logic        res_pace;
  logic [1:0]  res_mode;
  logic [9:0]  res_tenths;
  logic [20:0] res_rate;
  logic        slow_flag;
  logic        fast_flag;

  // tick evaluation
  logic [31:0] now_next;
  logic [16:0] el_inc;
  logic [1:0]  mode_s;
  logic [16:0] elapsed_s;
  logic [1:0]  mode_next;
  logic [16:0] elapsed_next;
  logic        log_beat;
  logic        log_paced;
  logic        pace_now;

  always_comb begin
    now_next  = now_ms + 32'd1;
    el_inc    = (elapsed_ms < ELAPSED_MAX) ? elapsed_ms + 17'd1 : elapsed_ms;
    mode_s    = mode_reg;
    elapsed_s = el_inc;
    log_beat  = 1'b0;
    log_paced = 1'b0;
    pace_now  = 1'b0;
    if (sense && mode_reg == MODE_READY) begin
      mode_s    = MODE_VRP;
      elapsed_s = '0;
      log_beat  = 1'b1;
    end
    mode_next    = mode_s;
    elapsed_next = elapsed_s;
    case (mode_s)
      MODE_VRP: begin
        if (elapsed_s >= {1'b0, refractory_ms}) begin
          elapsed_next = '0;
          mode_next    = MODE_RI;
        end
      end
      MODE_RI: begin
        if (elapsed_s >= {1'b0, upper_rate_ms}) begin
          mode_next = MODE_READY;
        end else if (elapsed_s >= {1'b0, lower_rate_ms}) begin
          pace_now = 1'b1;
        end
      end
      MODE_READY: begin
        if (elapsed_s >= {1'b0, lower_rate_ms}) begin
          pace_now = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (pace_now) begin
      log_beat     = 1'b1;
      log_paced    = 1'b1;
      elapsed_next = '0;
      mode_next    = MODE_VRP;
    end
  end

  // window and scan arithmetic
  logic [7:0]    w_eff;
  logic [17:0]   win_ms;
  logic [31:0]   age;
  logic          in_win;
  logic [CW:0]   start_sum;
  logic [CW:0]   start_wrap;
  logic          scan_issue;

  always_comb begin
    w_eff      = (window_s == 8'd0) ? 8'd1 : window_s;
    win_ms     = 18'(w_eff) * 18'd1000;
    age        = now_ms - rd_data[32:1];
    in_win     = (age <= {14'd0, win_ms});
    start_sum  = (CW + 1)'(write_slot) + DEPTH_X - (CW + 1)'(stored_count);
    start_wrap = (start_sum >= DEPTH_X) ? start_sum - DEPTH_X : start_sum;
    scan_issue = cmd.scan && (remain != '0);
  end

  // divider
  logic [NW-1:0]  numer;
  logic [DVW-1:0] denom;
  logic [NW-1:0]  quot;
  logic           div_busy;

  always_comb begin
    if (cmd.div_sel) begin
      numer = NW'(total) * NW'(6000);
      denom = DVW'(w_eff);
    end else begin
      numer = NW'(paced) * NW'(1000);
      denom = DVW'(total);
    end
  end

  vvi_div #(.NW(NW), .DW(DVW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .numer (numer),
    .denom (denom),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign status.div_busy  = div_busy;
  assign status.scan_done = (remain == '0) && !rd_valid;

  // config and timing state
  always_ff @(posedge clk) begin
    if (rst) begin
      refractory_ms      <= RST_REFRACTORY;
      upper_rate_ms      <= RST_UPPER_RATE;
      lower_rate_ms      <= RST_LOWER_RATE;
      window_s           <= RST_WINDOW;
      pace_threshold_pct <= RST_THRESHOLD;
      mode_reg           <= MODE_RI;
      elapsed_ms         <= '0;
      now_ms             <= '0;
      write_slot         <= '0;
      stored_count       <= '0;
      remain             <= '0;
      rd_valid           <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_REFRACTORY: refractory_ms      <= cfg_data;
          CFG_UPPER_RATE: upper_rate_ms      <= cfg_data;
          CFG_LOWER_RATE: lower_rate_ms      <= cfg_data;
          CFG_WINDOW:     window_s           <= cfg_data[7:0];
          CFG_THRESHOLD:  pace_threshold_pct <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
      if (cmd.tick) begin
        mode_reg   <= mode_next;
        elapsed_ms <= elapsed_next;
        now_ms     <= now_next;
        if (log_beat) begin
          write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + AW'(1);
          if (stored_count != DEPTH_C) begin
            stored_count <= stored_count + CW'(1);
          end
        end
      end
      if (cmd.rep_start) begin
        remain <= stored_count;
      end else if (scan_issue) begin
        remain <= remain - CW'(1);
      end
      rd_valid <= scan_issue;
    end
  end

  // beat ring
  always_ff @(posedge clk) begin
    if (cmd.tick && log_beat) begin
      beat_ring[write_slot] <= {now_next, log_paced};
    end
    if (scan_issue) begin
      rd_data <= beat_ring[ptr];
    end
  end

  // report accumulation and results
  always_ff @(posedge clk) begin
    if (cmd.rep_start) begin
      ptr      <= AW'(start_wrap);
      total    <= '0;
      paced    <= '0;
      res_pace <= 1'b0;
      res_mode <= mode_reg;
    end else if (scan_issue) begin
      ptr <= (ptr == LAST_SLOT) ? '0 : ptr + AW'(1);
    end
    if (cmd.tick) begin
      total      <= '0;
      paced      <= '0;
      res_pace   <= pace_now;
      res_mode   <= mode_next;
      res_tenths <= '0;
      res_rate   <= '0;
      slow_flag  <= 1'b0;
      fast_flag  <= 1'b0;
    end
    if (rd_valid && in_win) begin
      total <= total + CW'(1);
      if (rd_data[0]) begin
        paced <= paced + CW'(1);
      end
    end
    if (cmd.calc) begin
      slow_flag <= (total != '0) &&
                   (PW'(paced) * PW'(100) > PW'(pace_threshold_pct) * PW'(total));
      fast_flag <= (total > CW'(1)) &&
                   (PW'(total) * PW'(upper_rate_ms) > PW'(win_ms));
    end
    if (cmd.latch_q1) begin
      res_tenths <= (total != '0) ? 10'(quot) : '0;
    end
    if (cmd.latch_q2) begin
      res_rate <= (total > CW'(1)) ? 21'(quot) : '0;
    end
    if (cmd.publish) begin
      pace            <= res_pace;
      mode            <= res_mode;
      beat_count      <= 9'(total);
      paced_count     <= 9'(paced);
      paced_tenths    <= res_tenths;
      rate_hundredths <= res_rate;
      slow_alarm      <= slow_flag;
      fast_alarm      <= fast_flag;
    end
  end

endmodule

// ----- rtl/core/vvi_ctrl.sv -----
// ----------------------------------------------------------------------------
// vvi_ctrl
// Item sequencer: tick or report, window scan, two divisions, output word.
// ----------------------------------------------------------------------------
module vvi_ctrl import vvi_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_command,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output vvi_cmd_t    cmd,
  input  vvi_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_DIV1,
    S_WAIT1,
    S_DIV2,
    S_WAIT2,
    S_DONE
  } state_t;

  state_t state;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.tick      = accept && !in_command;
    cmd.rep_start = accept && in_command;
    case (state)
      S_SCAN:  cmd.scan = 1'b1;
      S_CALC:  cmd.calc = 1'b1;
      S_DIV1:  cmd.div_start = 1'b1;
      S_WAIT1: cmd.latch_q1 = !status.div_busy;
      S_DIV2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = 1'b1;
      end
      S_WAIT2: begin
        cmd.div_sel  = 1'b1;
        cmd.latch_q2 = !status.div_busy;
      end
      S_DONE:  cmd.publish = !out_valid || !out_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= in_command ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (status.scan_done) begin
            state <= S_CALC;
          end
        end
        S_CALC:  state <= S_DIV1;
        S_DIV1:  state <= S_WAIT1;
        S_WAIT1: begin
          if (!status.div_busy) begin
            state <= S_DIV2;
          end
        end
        S_DIV2:  state <= S_WAIT2;
        S_WAIT2: begin
          if (!status.div_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (cmd.publish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- verif/vvi_pacemaker_with_beat_monitor_core_tb.sv -----
// ----------------------------------------------------------------------------
// vvi_pacemaker_with_beat_monitor_core_tb
// Self-checking bench for the VVI timing cycle and beat monitor. A short
// stimulus table exercises reset state, ignored senses, the zero window and a
// pace, then several register settings run random tick and report words. Each
// word is predicted by an in-bench model of the cycle, the beat ring and
// the window statistics, or taken from the table; results are compared field
// by field in order. Input idles and output stalls at random outside calm runs.
// ----------------------------------------------------------------------------
module vvi_pacemaker_with_beat_monitor_core_tb;
  import vvi_pkg::*;

  localparam int   RING_DEPTH = 256;
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_REPORT = 1'b1;
  localparam int   SENSE_PCT  = 35;
  localparam int   IDLE_PCT   = 21;

  typedef struct packed {
    logic        pace;
    logic [1:0]  mode;
    logic [8:0]  total;
    logic [8:0]  paced;
    logic [9:0]  tenths;
    logic [20:0] rate;
    logic        slow;
    logic        fast;
  } pm_word_t;

  typedef struct {
    logic     cmd;
    logic     sns;
    bit       literal;
    bit       retune;
    pm_word_t want;
  } stim_row_t;

  typedef struct {
    logic [15:0] refr;
    logic [15:0] upper;
    logic [15:0] lower;
    logic [7:0]  win;
    logic [6:0]  thr;
    int          items;
    int          rep_pct;
    bit          calm_run;
    bit          drawn;
  } setting_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              command = CMD_TICK;
  logic              sense = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              pace;
  logic [1:0]        mode;
  logic [8:0]        beat_count;
  logic [8:0]        paced_count;
  logic [9:0]        paced_tenths;
  logic [20:0]       rate_hundredths;
  logic              slow_alarm;
  logic              fast_alarm;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index = CFG_REFRACTORY;
  logic [15:0]       cfg_data = '0;

  vvi_pacemaker_with_beat_monitor_core #(.BEAT_DEPTH(RING_DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .sense(sense),
    .out_valid(out_valid), .out_stall(out_stall),
    .pace(pace), .mode(mode), .beat_count(beat_count), .paced_count(paced_count),
    .paced_tenths(paced_tenths), .rate_hundredths(rate_hundredths),
    .slow_alarm(slow_alarm), .fast_alarm(fast_alarm),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // pacing model state
  logic [1:0]  cur_mode;
  logic [16:0] elapsed;
  logic [31:0] now_ms;
  logic [31:0] beat_time [RING_DEPTH];
  logic        beat_paced [RING_DEPTH];
  logic [7:0]  write_slot;
  logic [8:0]  stored;
  logic [15:0] refr_ms, upper_ms, lower_ms;
  logic [7:0]  window_s;
  logic [6:0]  thresh_pct;

  pm_word_t pending_words [$];
  int       mismatches = 0;
  int       n_ticks = 0, n_reports = 0, n_paced = 0, n_sensed = 0, n_settings = 0;
  int       peak_stored = 0;
  bit       calm = 1'b0;

  function automatic void reset_pacer();
    cur_mode   = MODE_RI;
    elapsed    = '0;
    now_ms     = '0;
    write_slot = '0;
    stored     = '0;
    refr_ms    = RST_REFRACTORY;
    upper_ms   = RST_UPPER_RATE;
    lower_ms   = RST_LOWER_RATE;
    window_s   = RST_WINDOW;
    thresh_pct = RST_THRESHOLD;
  endfunction

  function automatic void log_beat(input logic paced);
    beat_time[write_slot]  = now_ms;
    beat_paced[write_slot] = paced;
    write_slot = write_slot + 8'd1;
    if (stored < RING_DEPTH) stored = stored + 9'd1;
    if (stored > peak_stored) peak_stored = stored;
    elapsed  = '0;
    cur_mode = MODE_VRP;
    if (paced) n_paced++;
    else n_sensed++;
  endfunction

  function automatic pm_word_t pacer_step(input logic cmd, input logic sns);
    pm_word_t        r;
    longint unsigned w, total, paced;
    logic [31:0]     age;
    int              cnt, idx, i;
    r = '0;
    if (cmd == CMD_TICK) begin
      n_ticks++;
      now_ms = now_ms + 32'd1;
      if (elapsed != ELAPSED_MAX) elapsed = elapsed + 17'd1;
      if (sns && cur_mode == MODE_READY) log_beat(1'b0);
      case (cur_mode)
        MODE_VRP: begin
          if (elapsed >= refr_ms) begin
            elapsed  = '0;
            cur_mode = MODE_RI;
          end
        end
        MODE_RI: begin
          if (elapsed >= upper_ms) begin
            cur_mode = MODE_READY;
          end else if (elapsed >= lower_ms) begin
            log_beat(1'b1);
            r.pace = 1'b1;
          end
        end
        default: begin
          if (elapsed >= lower_ms) begin
            log_beat(1'b1);
            r.pace = 1'b1;
          end
        end
      endcase
    end else begin
      n_reports++;
      w = (window_s == 0) ? 1 : window_s;
      total = 0;
      paced = 0;
      cnt = stored;
      for (i = 0; i < cnt; i++) begin
        idx = (write_slot + 2 * RING_DEPTH - cnt + i) % RING_DEPTH;
        age = now_ms - beat_time[idx];
        if (age <= w * 1000) begin
          total++;
          if (beat_paced[idx]) paced++;
        end
      end
      r.total = 9'(total);
      r.paced = 9'(paced);
      if (total > 0) begin
        r.tenths = 10'(paced * 1000 / total);
        r.slow   = (paced * 100 > thresh_pct * total);
      end
      if (total > 1) begin
        r.rate = 21'(total * 6000 / w);
        r.fast = (total * upper_ms > w * 1000);
      end
    end
    r.mode = cur_mode;
    return r;
  endfunction

  function automatic pm_word_t quiet_word(input logic [1:0] m);
    pm_word_t r;
    r = '0;
    r.mode = m;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    pm_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        $error("result word with nothing outstanding");
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        check_field("pace", want.pace, pace);
        check_field("mode", want.mode, mode);
        check_field("beat_count", want.total, beat_count);
        check_field("paced_count", want.paced, paced_count);
        check_field("paced_tenths", want.tenths, paced_tenths);
        check_field("rate_hundredths", want.rate, rate_hundredths);
        check_field("slow_alarm", want.slow, slow_alarm);
        check_field("fast_alarm", want.fast, fast_alarm);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || calm) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
  end

  task automatic send_word(input logic cmd, input logic sns, input bit literal,
                           input pm_word_t lit_word);
    pm_word_t predicted;
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    sense    <= sns;
    predicted = pacer_step(cmd, sns);
    pending_words.push_back(literal ? lit_word : predicted);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_REFRACTORY: refr_ms    = val;
      CFG_UPPER_RATE: upper_ms   = val;
      CFG_LOWER_RATE: lower_ms   = val;
      CFG_WINDOW:     window_s   = val[7:0];
      CFG_THRESHOLD:  thresh_pct = val[6:0];
      default: ;
    endcase
  endtask

  task automatic program_regs(input setting_t s);
    write_reg(CFG_REFRACTORY, s.refr);
    write_reg(CFG_UPPER_RATE, s.upper);
    write_reg(CFG_LOWER_RATE, s.lower);
    write_reg(CFG_WINDOW, {8'd0, s.win});
    write_reg(CFG_THRESHOLD, {9'd0, s.thr});
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  initial begin
    stim_row_t plan [$];
    setting_t  runs [$];
    setting_t  tune, s;
    int        k;
    reset_pacer();

    // refractory 1, upper 2, lower 3, zero window, threshold 0
    tune = '{16'd1, 16'd2, 16'd3, 8'd0, 7'd0, 0, 0, 1'b0, 1'b0};
    plan.push_back('{CMD_REPORT, 1'b0, 1'b1, 1'b0, quiet_word(MODE_RI)});
    plan.push_back('{CMD_TICK,   1'b1, 1'b1, 1'b0, quiet_word(MODE_RI)});
    plan.push_back('{CMD_REPORT, 1'b1, 1'b1, 1'b0, quiet_word(MODE_RI)});
    plan.push_back('{CMD_TICK,   1'b0, 1'b1, 1'b0, quiet_word(MODE_RI)});
    plan.push_back('{CMD_TICK,   1'b0, 1'b0, 1'b1, '0});
    plan.push_back('{CMD_TICK,   1'b1, 1'b0, 1'b0, '0});
    plan.push_back('{CMD_TICK,   1'b1, 1'b0, 1'b0, '0});
    plan.push_back('{CMD_TICK,   1'b0, 1'b0, 1'b0, '0});
    plan.push_back('{CMD_TICK,   1'b0, 1'b0, 1'b0, '0});
    plan.push_back('{CMD_TICK,   1'b0, 1'b0, 1'b0, '0});
    plan.push_back('{CMD_REPORT, 1'b0, 1'b0, 1'b0, '0});
    plan.push_back('{CMD_TICK,   1'b0, 1'b0, 1'b0, '0});
    plan.push_back('{CMD_TICK,   1'b0, 1'b0, 1'b0, '0});
    plan.push_back('{CMD_TICK,   1'b1, 1'b0, 1'b0, '0});
    plan.push_back('{CMD_TICK,   1'b1, 1'b0, 1'b0, '0});
    plan.push_back('{CMD_REPORT, 1'b1, 1'b0, 1'b0, '0});

    runs.push_back('{16'd1,     16'd1,     16'd1,     8'd1,   7'd0,   300, 8,  1'b0, 1'b0});
    runs.push_back('{16'd1,     16'd65535, 16'd1,     8'd255, 7'd100, 300, 8,  1'b1, 1'b0});
    runs.push_back('{16'd65535, 16'd65535, 16'd65535, 8'd255, 7'd127, 120, 20, 1'b0, 1'b0});
    runs.push_back('{16'd3,     16'd20,    16'd8,     8'd0,   7'd50,  220, 8,  1'b0, 1'b0});
    runs.push_back('{RST_REFRACTORY, RST_UPPER_RATE, RST_LOWER_RATE, RST_WINDOW,
                     RST_THRESHOLD, 400, 3, 1'b0, 1'b0});
    runs.push_back('{16'd2,     16'd4,     16'd6,     8'd1,   7'd100, 250, 5,  1'b0, 1'b0});
    runs.push_back('{16'd0,     16'd0,     16'd0,     8'd0,   7'd0,   120, 10, 1'b0, 1'b1});
    runs.push_back('{16'd0,     16'd0,     16'd0,     8'd0,   7'd0,   120, 10, 1'b0, 1'b1});

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[r]) begin
      if (plan[r].retune) begin
        settle();
        program_regs(tune);
      end
      send_word(plan[r].cmd, plan[r].sns, plan[r].literal, plan[r].want);
    end

    foreach (runs[p]) begin
      s = runs[p];
      if (s.drawn) begin
        s.refr  = 16'($urandom_range(1, 40));
        s.upper = 16'($urandom_range(1, 80));
        s.lower = 16'($urandom_range(1, 120));
        s.win   = 8'($urandom_range(0, 3));
        s.thr   = 7'($urandom_range(0, 127));
      end
      settle();
      program_regs(s);
      calm = s.calm_run;
      for (k = 0; k < s.items; k++)
        send_word(($urandom_range(0, 99) < s.rep_pct) ? CMD_REPORT : CMD_TICK,
                  ($urandom_range(0, 99) < SENSE_PCT), 1'b0, '0);
      calm = 1'b0;
    end

    settle();
    repeat (400) @(posedge clk);
    $display("Ran %0d tick and %0d report words over %0d register settings.",
             n_ticks, n_reports, n_settings);
    $display("Logged %0d paced and %0d sensed beats, ring peak %0d of %0d entries.",
             n_paced, n_sensed, peak_stored, RING_DEPTH);
    if (mismatches == 0) begin
      $display("vvi_pacemaker_with_beat_monitor_core_tb OK");
    end else begin
      $display("vvi_pacemaker_with_beat_monitor_core_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("vvi_pacemaker_with_beat_monitor_core_tb NOT OK");
    $finish;
  end

endmodule

// ----- vvi_pacemaker_with_beat_monitor_core.f -----
rtl/core/vvi_pkg.sv
rtl/core/vvi_div.sv
rtl/core/vvi_datapath.sv
rtl/core/vvi_ctrl.sv
rtl/core/vvi_pacemaker_with_beat_monitor_core.sv
verif/vvi_pacemaker_with_beat_monitor_core_tb.sv
